>>> src/spq_pkg.sv
package spq_pkg;

    localparam int DEFAULT_DEPTH     = 64;
    localparam int DEFAULT_ID_BITS   = 16;
    localparam int DEFAULT_COST_BITS = 24;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_POP    = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_PREV = 2'd0,
        RD_CUR  = 2'd1,
        RD_NEXT = 2'd2,
        RD_HEAD = 2'd3
    } rd_sel_t;

    typedef enum logic {
        WR_NEW   = 1'b0,
        WR_MOVED = 1'b1
    } wr_src_t;

    typedef struct packed {
        logic    load;
        logic    k_to_occ;
        logic    k_to_zero;
        logic    k_inc;
        logic    k_dec;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_src_t wr_src;
        logic    occ_inc;
        logic    occ_dec;
        logic    occ_clear;
        logic    set_status;
        status_t status;
        logic    pop_cap;
        logic    head_cap;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic occ_zero;
        logic occ_full;
        logic k_zero;
        logic k_end;
        logic k_last;
        logic cost_gt;
        logic id_eq;
        logic out_busy;
    } flags_t;

endpackage

>>> src/spq_ram.sv
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/spq_datapath.sv
module spq_datapath #(
    parameter int DEPTH     = spq_pkg::DEFAULT_DEPTH,
    parameter int ID_BITS   = spq_pkg::DEFAULT_ID_BITS,
    parameter int COST_BITS = spq_pkg::DEFAULT_COST_BITS,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spq_pkg::cmd_t        cmd,
    output spq_pkg::flags_t      flags,
    input  logic [1:0]           req_type,
    input  logic [ID_BITS-1:0]   entry_id,
    input  logic [COST_BITS-1:0] entry_cost,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [1:0]           status,
    output logic [ID_BITS-1:0]   popped_id,
    output logic [COST_BITS-1:0] popped_cost,
    output logic                 head_valid,
    output logic [ID_BITS-1:0]   head_id,
    output logic [COST_BITS-1:0] head_cost,
    output logic [CW-1:0]        entry_count
);
    import spq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W  = ID_BITS + COST_BITS;

    req_t                 req_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [CW-1:0]        occ_reg;
    logic [CW-1:0]        k_reg;

    status_t              wk_status_reg;
    logic [ID_BITS-1:0]   wk_pid_reg;
    logic [COST_BITS-1:0] wk_pcost_reg;
    logic                 wk_hvalid_reg;
    logic [ID_BITS-1:0]   wk_hid_reg;
    logic [COST_BITS-1:0] wk_hcost_reg;
    logic [CW-1:0]        wk_count_reg;

    logic                 rsp_valid_reg;
    status_t              status_reg;
    logic [ID_BITS-1:0]   pid_reg;
    logic [COST_BITS-1:0] pcost_reg;
    logic                 hvalid_reg;
    logic [ID_BITS-1:0]   hid_reg;
    logic [COST_BITS-1:0] hcost_reg;
    logic [CW-1:0]        count_reg;

    logic [CW-1:0]        k_plus;
    logic [CW-1:0]        k_minus;
    logic [CW-1:0]        rd_k;
    logic [W-1:0]         rd_data;
    logic [W-1:0]         wr_data;
    logic [ID_BITS-1:0]   rd_id;
    logic [COST_BITS-1:0] rd_cost;

    assign k_plus  = k_reg + CW'(1);
    assign k_minus = k_reg - CW'(1);
    assign rd_id   = rd_data[W-1:COST_BITS];
    assign rd_cost = rd_data[COST_BITS-1:0];

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_PREV: rd_k = k_minus;
            RD_CUR:  rd_k = k_reg;
            RD_NEXT: rd_k = k_plus;
            RD_HEAD: rd_k = '0;
            default: rd_k = '0;
        endcase
    end

    assign wr_data = (cmd.wr_src == WR_NEW) ? {id_reg, cost_reg} : rd_data;

    spq_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (k_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_k[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        flags.req      = req_reg;
        flags.occ_zero = (occ_reg == '0);
        flags.occ_full = (occ_reg == CW'(DEPTH));
        flags.k_zero   = (k_reg == '0);
        flags.k_end    = (k_reg >= occ_reg);
        flags.k_last   = (k_plus >= occ_reg);
        flags.cost_gt  = (rd_cost > cost_reg);
        flags.id_eq    = (rd_id == id_reg);
        flags.out_busy = rsp_valid_reg;
    end

    // request and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= req_t'(req_type);
            id_reg        <= entry_id;
            cost_reg      <= entry_cost;
            wk_status_reg <= ST_OK;
            wk_pid_reg    <= '0;
            wk_pcost_reg  <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                wk_status_reg <= cmd.status;
            end
            if (cmd.pop_cap)
            begin
                wk_pid_reg   <= rd_id;
                wk_pcost_reg <= rd_cost;
            end
        end
        if (cmd.occ_clear)
        begin
            wk_count_reg <= occ_reg;
        end
        if (cmd.head_cap)
        begin
            wk_hvalid_reg <= (occ_reg != '0);
            wk_hid_reg    <= (occ_reg != '0) ? rd_id : '0;
            wk_hcost_reg  <= (occ_reg != '0) ? rd_cost : '0;
        end
        priority if (cmd.k_to_occ)
        begin
            k_reg <= occ_reg;
        end
        else if (cmd.k_to_zero)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_plus;
        end
        else if (cmd.k_dec)
        begin
            k_reg <= k_minus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            priority if (cmd.occ_clear)
            begin
                occ_reg <= '0;
            end
            else if (cmd.occ_inc)
            begin
                occ_reg <= occ_reg + CW'(1);
            end
            else if (cmd.occ_dec)
            begin
                occ_reg <= occ_reg - CW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= wk_status_reg;
            pid_reg    <= wk_pid_reg;
            pcost_reg  <= wk_pcost_reg;
            hvalid_reg <= wk_hvalid_reg;
            hid_reg    <= wk_hid_reg;
            hcost_reg  <= wk_hcost_reg;
            count_reg  <= (req_reg == REQ_CLEAR) ? wk_count_reg : occ_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign popped_id   = pid_reg;
    assign popped_cost = pcost_reg;
    assign head_valid  = hvalid_reg;
    assign head_id     = hid_reg;
    assign head_cost   = hcost_reg;
    assign entry_count = count_reg;

endmodule

>>> src/spq_ctrl.sv
module spq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  spq_pkg::flags_t flags,
    output spq_pkg::cmd_t   cmd
);
    import spq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_CMP,
        S_RM_SCAN,
        S_RM_CMP,
        S_POP_RD,
        S_POP_CAP,
        S_SH_CHK,
        S_SH_WR,
        S_HEAD,
        S_HEAD_CAP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (flags.req)
                    REQ_INSERT:
                    begin
                        if (flags.occ_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                            state_next     = S_HEAD;
                        end
                        else
                        begin
                            cmd.k_to_occ = 1'b1;
                            state_next   = S_INS_CHK;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        cmd.k_to_zero = 1'b1;
                        state_next    = S_RM_SCAN;
                    end
                    REQ_POP:
                    begin
                        if (flags.occ_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EMPTY;
                            state_next     = S_HEAD;
                        end
                        else
                        begin
                            cmd.k_to_zero = 1'b1;
                            state_next    = S_POP_RD;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.occ_clear = 1'b1;
                        state_next    = S_HEAD;
                    end
                    default:
                    begin
                        state_next = S_HEAD;
                    end
                endcase
            end
            // walk down from the tail, moving costlier entries up one slot
            S_INS_CHK:
            begin
                if (flags.k_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_src  = WR_NEW;
                    cmd.occ_inc = 1'b1;
                    state_next  = S_HEAD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (flags.cost_gt)
                begin
                    cmd.wr_src = WR_MOVED;
                    cmd.k_dec  = 1'b1;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    cmd.wr_src  = WR_NEW;
                    cmd.occ_inc = 1'b1;
                    state_next  = S_HEAD;
                end
            end
            S_RM_SCAN:
            begin
                if (flags.k_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_HEAD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP:
            begin
                if (flags.id_eq)
                begin
                    state_next = S_SH_CHK;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_RM_SCAN;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = S_POP_CAP;
            end
            S_POP_CAP:
            begin
                cmd.pop_cap = 1'b1;
                state_next  = S_SH_CHK;
            end
            // close the gap at slot k
            S_SH_CHK:
            begin
                if (flags.k_last)
                begin
                    cmd.occ_dec = 1'b1;
                    state_next  = S_HEAD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_MOVED;
                cmd.k_inc  = 1'b1;
                state_next = S_SH_CHK;
            end
            S_HEAD:
            begin
                cmd.rd_en  = !flags.occ_zero;
                cmd.rd_sel = RD_HEAD;
                state_next = S_HEAD_CAP;
            end
            S_HEAD_CAP:
            begin
                cmd.head_cap = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!flags.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/sorted_priority_queue.sv
// clear, full insert and empty pop go straight to the head read; insert moves each costlier
//   entry one slot toward the tail, remove scans from the head for the id, and pop and a
//   found remove shift the entries behind the gap one slot toward the head
// throughput: one request at a time, req_ready rises again together with rsp_valid; the
//   done state holds while the last result waits, a new request is taken while it waits
// reset: asynchronous active low, empties the queue, entry storage is not cleared
module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEFAULT_DEPTH,
    parameter int ID_BITS   = spq_pkg::DEFAULT_ID_BITS,
    parameter int COST_BITS = spq_pkg::DEFAULT_COST_BITS,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           req_type,
    input  logic [ID_BITS-1:0]   entry_id,
    input  logic [COST_BITS-1:0] entry_cost,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [1:0]           status,
    output logic [ID_BITS-1:0]   popped_id,
    output logic [COST_BITS-1:0] popped_cost,
    output logic                 head_valid,
    output logic [ID_BITS-1:0]   head_id,
    output logic [COST_BITS-1:0] head_cost,
    output logic [CW-1:0]        entry_count
);
    import spq_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .COST_BITS (COST_BITS),
        .CW        (CW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flags       (flags),
        .req_type    (req_type),
        .entry_id    (entry_id),
        .entry_cost  (entry_cost),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .popped_id   (popped_id),
        .popped_cost (popped_cost),
        .head_valid  (head_valid),
        .head_id     (head_id),
        .head_cost   (head_cost),
        .entry_count (entry_count)
    );

endmodule

>>> src/spq_checker.sv
module spq_checker #(
    parameter int DEPTH     = spq_pkg::DEFAULT_DEPTH,
    parameter int ID_BITS   = spq_pkg::DEFAULT_ID_BITS,
    parameter int COST_BITS = spq_pkg::DEFAULT_COST_BITS,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [1:0]           status,
    input logic [ID_BITS-1:0]   popped_id,
    input logic [COST_BITS-1:0] popped_cost,
    input logic                 head_valid,
    input logic [ID_BITS-1:0]   head_id,
    input logic [COST_BITS-1:0] head_cost,
    input logic [CW-1:0]        entry_count
);
    import spq_pkg::*;

    // stalled beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count)
            && $stable(head_id) && $stable(popped_id))
        else $error("result beat changed while stalled");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !head_valid |-> head_id == '0 && head_cost == '0)
        else $error("empty queue shows a head");

    a_fail_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> popped_id == '0 && popped_cost == '0)
        else $error("failed request reports a popped entry");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> entry_count == CW'(DEPTH) && head_valid)
        else $error("full status with room left");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= CW'(DEPTH))
        else $error("entry count above depth");

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .COST_BITS (COST_BITS),
    .CW        (CW)
) u_spq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .popped_id   (popped_id),
    .popped_cost (popped_cost),
    .head_valid  (head_valid),
    .head_id     (head_id),
    .head_cost   (head_cost),
    .entry_count (entry_count)
);
